// ----- sv/tmpr_pkg.sv -----
// Shared types, request codes and palette table for the tile map pixel renderer.
package tmpr_pkg;

   // Request action codes
   localparam logic [1:0] ACT_PATTERN_WRITE = 2'd0;
   localparam logic [1:0] ACT_CELL_WRITE    = 2'd1;
   localparam logic [1:0] ACT_FLAG_WRITE    = 2'd2;
   localparam logic [1:0] ACT_PIXEL_READ    = 2'd3;

   // One map cell as held in the cell store
   typedef struct packed {
      logic       mirror_y;
      logic       mirror_x;
      logic [2:0] colour;
      logic [1:0] bank;
      logic [7:0] tile;
   } cell_type;

   // Foreground palette, packed as red, green, blue
   function automatic logic [23:0] palette_rgb(input logic [2:0] idx);
      logic [23:0] rgb;
      case (idx)
         3'd0: rgb = 24'hFF_FF_FF;
         3'd1: rgb = 24'hFF_20_20;
         3'd2: rgb = 24'hFF_A0_00;
         3'd3: rgb = 24'hFF_F0_00;
         3'd4: rgb = 24'h20_E0_40;
         3'd5: rgb = 24'h00_E0_E8;
         3'd6: rgb = 24'h30_60_FF;
         3'd7: rgb = 24'hF0_20_D0;
         default: rgb = 24'h00_00_00;
      endcase
      return rgb;
   endfunction

endpackage

// ----- sv/tmpr_cell_ram.sv -----
// Map cell store: one write port, one registered read port.
module tmpr_cell_ram #(
   parameter int DEPTH = 192,
   parameter int AW    = 8
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  tmpr_pkg::cell_type  wr_data,
   input  logic [AW-1:0]       rd_addr,
   output tmpr_pkg::cell_type  rd_data
);
   import tmpr_pkg::*;

   cell_type cell_mem_ff [DEPTH];
   cell_type rd_data_ff;

   // Write, then read with old-data semantics on a same-address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= cell_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/tmpr_pattern_ram.sv -----
// Pattern store: one tile row byte per entry, one write port, one registered read port.
module tmpr_pattern_ram #(
   parameter int DEPTH = 8192,
   parameter int AW    = 13
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);
   logic [7:0] pat_mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   // Write, then read with old-data semantics on a same-address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pat_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= pat_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/tile_map_pixel_renderer_core.sv -----
// Top level: request decode, cell and pattern lookup pipeline and pixel output.
//
// The renderer takes one request every clock; busy never rises. A pixel read
// raises rsp_strobe after the cell read, the pattern read and the output
// register; writes and flag updates answer nothing. Two synchronous memory
// reads are chained: the map cell store is read at the edge that takes the
// request, the pattern store at the following edge at the address the cell
// names, and the output register holds the pixel after that. Writes land in
// the memories at the edge that takes them, so a pixel read always sees every
// earlier write and none of the later ones. Results cannot be held off: sample
// rsp_red, rsp_green and rsp_blue in the cycle rsp_strobe is high.
module tile_map_pixel_renderer_core #(
   parameter int BANK_COUNT     = 4,
   parameter int TILES_PER_BANK = 256,
   parameter int CELLS_ACROSS   = 16,
   parameter int CELLS_DOWN     = 12
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_action,
   input  logic [1:0] req_bank_sel,
   input  logic [7:0] req_tile_number,
   input  logic [2:0] req_tile_row,
   input  logic [7:0] req_data_byte,
   input  logic [7:0] req_cell_index,
   input  logic [2:0] req_colour_index,
   input  logic       req_mirror_x,
   input  logic       req_mirror_y,
   input  logic [7:0] req_pixel_x,
   input  logic [7:0] req_pixel_y,
   output logic       rsp_strobe,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue
);
   import tmpr_pkg::*;

   localparam int PAT_DEPTH  = BANK_COUNT * TILES_PER_BANK * 8;
   localparam int CELL_DEPTH = CELLS_ACROSS * CELLS_DOWN;
   localparam int PAT_AW     = (PAT_DEPTH > 1) ? $clog2(PAT_DEPTH) : 1;
   localparam int CELL_AW    = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;

   logic                accept;
   logic [6:0]          logic_x;
   logic [6:0]          logic_y;
   logic                pixel_on_map;

   logic                pat_wr_en;
   logic [PAT_AW-1:0]   pat_wr_addr;
   logic [PAT_AW-1:0]   pat_rd_addr;
   logic [7:0]          pat_rd_data;

   logic                cell_wr_en;
   logic [CELL_AW-1:0]  cell_wr_addr;
   cell_type            cell_wr_data;
   logic [CELL_AW-1:0]  cell_rd_addr;
   cell_type            cell_rd_data;

   logic                patterns_ready_ff, patterns_ready_in;
   logic                cells_ready_ff, cells_ready_in;

   logic                s1_valid_ff, s1_valid_in;
   logic                s1_draw_ff, s1_draw_in;
   logic [2:0]          s1_sx_ff, s1_sx_in;
   logic [2:0]          s1_sy_ff, s1_sy_in;

   logic                s2_valid_ff, s2_valid_in;
   logic                s2_draw_ff, s2_draw_in;
   logic [2:0]          s2_bit_sel_ff, s2_bit_sel_in;
   logic [2:0]          s2_colour_ff, s2_colour_in;
   logic [2:0]          s2_row;
   logic                cell_ok;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [23:0]         rsp_rgb_ff, rsp_rgb_in;
   logic                pixel_bit;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Decode writes into the two stores
   assign pat_wr_en   = accept && (req_action == ACT_PATTERN_WRITE)
                        && (int'(req_bank_sel) < BANK_COUNT)
                        && (int'(req_tile_number) < TILES_PER_BANK);
   assign pat_wr_addr = PAT_AW'((int'(req_bank_sel) * TILES_PER_BANK
                        + int'(req_tile_number)) * 8 + int'(req_tile_row));

   assign cell_wr_en   = accept && (req_action == ACT_CELL_WRITE)
                         && (int'(req_cell_index) < CELL_DEPTH);
   assign cell_wr_addr = CELL_AW'(req_cell_index);
   always_comb begin
      cell_wr_data          = '0;
      cell_wr_data.tile     = req_tile_number;
      cell_wr_data.bank     = req_bank_sel;
      cell_wr_data.colour   = req_colour_index;
      cell_wr_data.mirror_x = req_mirror_x;
      cell_wr_data.mirror_y = req_mirror_y;
   end

   // Halve the framebuffer pixel and pick its map cell
   assign logic_x      = req_pixel_x[7:1];
   assign logic_y      = req_pixel_y[7:1];
   assign pixel_on_map = (int'(logic_x) < CELLS_ACROSS * 8)
                         && (int'(logic_y) < CELLS_DOWN * 8);
   assign cell_rd_addr = CELL_AW'(int'(logic_y[6:3]) * CELLS_ACROSS + int'(logic_x[6:3]));

   // Update loaded flags
   always_comb begin
      patterns_ready_in = patterns_ready_ff;
      cells_ready_in    = cells_ready_ff;
      if (accept && (req_action == ACT_FLAG_WRITE)) begin
         patterns_ready_in = req_data_byte[0];
         cells_ready_in    = req_data_byte[1];
      end
   end

   // Stage 1: cell read in flight
   assign s1_valid_in = accept && (req_action == ACT_PIXEL_READ);
   assign s1_draw_in  = patterns_ready_ff && cells_ready_ff && pixel_on_map;
   assign s1_sx_in    = logic_x[2:0];
   assign s1_sy_in    = logic_y[2:0];

   // Stage 2: apply flips, check the cell and issue the pattern read
   assign cell_ok       = (int'(cell_rd_data.bank) < BANK_COUNT)
                          && (int'(cell_rd_data.tile) < TILES_PER_BANK);
   assign s2_row        = s1_sy_ff ^ {3{cell_rd_data.mirror_y}};
   assign s2_valid_in   = s1_valid_ff;
   assign s2_draw_in    = s1_draw_ff && cell_ok;
   assign s2_bit_sel_in = s1_sx_ff ^ {3{cell_rd_data.mirror_x}};
   assign s2_colour_in  = cell_rd_data.colour;
   assign pat_rd_addr   = PAT_AW'((int'(cell_rd_data.bank) * TILES_PER_BANK
                          + int'(cell_rd_data.tile)) * 8 + int'(s2_row));

   // Output stage: select the pixel bit, color it or drop to black
   assign pixel_bit     = pat_rd_data[~s2_bit_sel_ff];
   assign rsp_strobe_in = s2_valid_ff;
   assign rsp_rgb_in    = (s2_draw_ff && pixel_bit) ? palette_rgb(s2_colour_ff) : 24'h0;

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         patterns_ready_ff <= 1'b0;
         cells_ready_ff    <= 1'b0;
         s1_valid_ff       <= 1'b0;
         s2_valid_ff       <= 1'b0;
         rsp_strobe_ff     <= 1'b0;
      end else begin
         patterns_ready_ff <= patterns_ready_in;
         cells_ready_ff    <= cells_ready_in;
         s1_valid_ff       <= s1_valid_in;
         s2_valid_ff       <= s2_valid_in;
         rsp_strobe_ff     <= rsp_strobe_in;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      s1_draw_ff    <= s1_draw_in;
      s1_sx_ff      <= s1_sx_in;
      s1_sy_ff      <= s1_sy_in;
      s2_draw_ff    <= s2_draw_in;
      s2_bit_sel_ff <= s2_bit_sel_in;
      s2_colour_ff  <= s2_colour_in;
      rsp_rgb_ff    <= rsp_rgb_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_red    = rsp_rgb_ff[23:16];
   assign rsp_green  = rsp_rgb_ff[15:8];
   assign rsp_blue   = rsp_rgb_ff[7:0];

   tmpr_cell_ram #(
      .DEPTH (CELL_DEPTH),
      .AW    (CELL_AW)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_wr_en),
      .wr_addr (cell_wr_addr),
      .wr_data (cell_wr_data),
      .rd_addr (cell_rd_addr),
      .rd_data (cell_rd_data)
   );

   tmpr_pattern_ram #(
      .DEPTH (PAT_DEPTH),
      .AW    (PAT_AW)
   ) u_pattern_ram (
      .clock   (clock),
      .wr_en   (pat_wr_en),
      .wr_addr (pat_wr_addr),
      .wr_data (req_data_byte),
      .rd_addr (pat_rd_addr),
      .rd_data (pat_rd_data)
   );

endmodule
